/* rtl/piem_pkg.sv */
// types, constants and helper functions for the pad input event merger
// no dependencies; imported by pad_input_event_merger_top
`default_nettype none

package piem_pkg;

    localparam int NUM_ZONES = 10;
    localparam int CFG_IDX_W = 4;
    localparam int SIZE_W    = 12;
    localparam int PCT_W     = 7;
    localparam int PROD_W    = SIZE_W + PCT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = CFG_IDX_W'(1);

    localparam logic [SIZE_W-1:0] PANEL_WIDTH_RESET  = 12'd480;
    localparam logic [SIZE_W-1:0] PANEL_HEIGHT_RESET = 12'd720;
    localparam logic [PCT_W-1:0]  PCT_FULL           = 7'd100;

    localparam logic [4:0] EV_KEY = 5'd1;
    localparam logic [4:0] EV_ABS = 5'd3;

    localparam logic [9:0] ABS_X        = 10'd0;
    localparam logic [9:0] ABS_Y        = 10'd1;
    localparam logic [9:0] ABS_MT_X     = 10'd53;
    localparam logic [9:0] ABS_MT_Y     = 10'd54;
    localparam logic [9:0] ABS_MT_TRACK = 10'd57;

    localparam logic [9:0] CODE_TOUCH       = 10'd330;
    localparam logic [9:0] CODE_NAV_UP      = 10'd103;
    localparam logic [9:0] CODE_VOL_UP      = 10'd115;
    localparam logic [9:0] CODE_NAV_DOWN    = 10'd108;
    localparam logic [9:0] CODE_VOL_DOWN    = 10'd114;
    localparam logic [9:0] CODE_NAV_LEFT    = 10'd105;
    localparam logic [9:0] CODE_PREV_TRACK  = 10'd165;
    localparam logic [9:0] CODE_NAV_RIGHT   = 10'd106;
    localparam logic [9:0] CODE_CONFIRM     = 10'd28;
    localparam logic [9:0] CODE_PLAY_TOGGLE = 10'd164;
    localparam logic [9:0] CODE_NEXT_TRACK  = 10'd163;
    localparam logic [9:0] CODE_ERASE       = 10'd14;
    localparam logic [9:0] CODE_HALT        = 10'd128;
    localparam logic [9:0] CODE_BLANK       = 10'd57;
    localparam logic [9:0] CODE_NEXT_FIELD  = 10'd15;
    localparam logic [9:0] CODE_CANCEL      = 10'd1;
    localparam logic [9:0] CODE_PWR         = 10'd116;

    localparam logic [2:0] BIT_UP     = 3'd0;
    localparam logic [2:0] BIT_DOWN   = 3'd1;
    localparam logic [2:0] BIT_LEFT   = 3'd2;
    localparam logic [2:0] BIT_RIGHT  = 3'd3;
    localparam logic [2:0] BIT_A      = 3'd4;
    localparam logic [2:0] BIT_B      = 3'd5;
    localparam logic [2:0] BIT_START  = 3'd6;
    localparam logic [2:0] BIT_SELECT = 3'd7;

    localparam int ZONE_VOL_DOWN = 8;
    localparam int ZONE_VOL_UP   = 9;

    localparam logic [10:0] VOL_STEP   = 11'd10;
    localparam logic [10:0] VOL_MAX    = 11'd1024;
    localparam logic [10:0] VOL_RESET  = 11'd20;
    localparam logic [4:0]  HOLD_FIRST = 5'd25;
    localparam logic [4:0]  HOLD_LAST  = 5'd29;

    typedef struct packed {
        logic               mode;
        logic [4:0]         event_type;
        logic [9:0]         event_code;
        logic signed [31:0] event_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  buttons;
        logic [9:0]  zone_hits;
        logic [10:0] volume;
        logic        quit;
    } t_out_item;

    typedef struct packed {
        logic [PCT_W-1:0] x0;
        logic [PCT_W-1:0] y0;
        logic [PCT_W-1:0] x1;
        logic [PCT_W-1:0] y1;
        logic [3:0]       hit_bit;
    } t_zone;

    localparam t_zone ZONE_TAB [NUM_ZONES] = '{
        '{7'd11, 7'd62, 7'd27, 7'd72,  4'd0},
        '{7'd11, 7'd82, 7'd27, 7'd92,  4'd1},
        '{7'd1,  7'd72, 7'd16, 7'd82,  4'd2},
        '{7'd23, 7'd72, 7'd38, 7'd82,  4'd3},
        '{7'd76, 7'd64, 7'd96, 7'd76,  4'd4},
        '{7'd56, 7'd76, 7'd76, 7'd88,  4'd5},
        '{7'd30, 7'd93, 7'd50, 7'd100, 4'd7},
        '{7'd52, 7'd93, 7'd72, 7'd100, 4'd6},
        '{7'd35, 7'd62, 7'd49, 7'd72,  4'd8},
        '{7'd51, 7'd62, 7'd65, 7'd72,  4'd9}
    };

    // edge in hundredths times panel size, compared against 100 * (pos + 1)
    function automatic logic [PROD_W-1:0] edge_prod(
        input logic [PCT_W-1:0]  pct,
        input logic [SIZE_W-1:0] size
    );
        logic [PROD_W-1:0] p;
        p = PROD_W'(pct) * PROD_W'(size);
        return p;
    endfunction

    function automatic logic [10:0] vol_up(input logic [10:0] v);
        logic [11:0] s;
        s = 12'(v) + 12'(VOL_STEP);
        return (s > 12'(VOL_MAX)) ? VOL_MAX : s[10:0];
    endfunction

    function automatic logic [10:0] vol_down(input logic [10:0] v);
        return (v > VOL_STEP) ? (v - VOL_STEP) : 11'd0;
    endfunction

    function automatic logic [4:0] hold_next(input logic [4:0] c);
        return (c >= HOLD_LAST) ? HOLD_FIRST : (c + 5'd1);
    endfunction

endpackage

`default_nettype wire

/* rtl/pad_input_event_merger_top.sv */
// pad input event merger: events update touch, key and quit state in the accept cycle;
// an end-of-poll transaction lands in the output register in the cycle after accept
// throughput one transaction per cycle; input stalls only while a result is held
// and the output is stalled. zone edges are kept as products refreshed on config write
// synchronous active-low reset; volume resets to 20, panel to 480 by 720
// depends on piem_pkg
`default_nettype none

module pad_input_event_merger_top
    import piem_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SIZE_W-1:0]    i_cfg_data
);

    logic [PROD_W-1:0] r_x0p [NUM_ZONES];
    logic [PROD_W-1:0] r_x1p [NUM_ZONES];
    logic [PROD_W-1:0] r_y0p [NUM_ZONES];
    logic [PROD_W-1:0] r_y1p [NUM_ZONES];

    logic signed [31:0] r_touch_x, n_touch_x;
    logic signed [31:0] r_touch_y, n_touch_y;
    logic               r_finger, n_finger;
    logic               r_moved, n_moved;
    logic [7:0]         r_keys, n_keys;
    logic [9:0]         r_zone, n_zone;
    logic               r_quit, n_quit;
    logic [10:0]        r_vol, n_vol;
    logic [4:0]         r_plus_cnt, n_plus_cnt;
    logic [4:0]         r_minus_cnt, n_minus_cnt;
    logic               r_out_valid;
    t_out_item          r_out, n_out;

    logic              in_acc;
    logic              key_hit;
    logic [2:0]        key_bit;
    logic              quit_key;
    logic              touch_key;
    logic              pressed;
    logic              x_neg, x_big, y_neg, y_big;
    logic [PROD_W-1:0] x_scl, y_scl;
    logic [9:0]        hits;
    logic [9:0]        zone_now;
    logic [10:0]       vol_mid;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pressed     = |i_in.event_value;

    always_comb begin
        key_hit   = 1'b0;
        key_bit   = BIT_UP;
        quit_key  = 1'b0;
        touch_key = 1'b0;
        unique case (i_in.event_code)
            CODE_TOUCH:                     touch_key = 1'b1;
            CODE_NAV_UP, CODE_VOL_UP:       begin key_hit = 1'b1; key_bit = BIT_UP; end
            CODE_NAV_DOWN, CODE_VOL_DOWN:   begin key_hit = 1'b1; key_bit = BIT_DOWN; end
            CODE_NAV_LEFT, CODE_PREV_TRACK: begin key_hit = 1'b1; key_bit = BIT_LEFT; end
            CODE_NAV_RIGHT:                 begin key_hit = 1'b1; key_bit = BIT_RIGHT; end
            CODE_CONFIRM, CODE_PLAY_TOGGLE: begin key_hit = 1'b1; key_bit = BIT_A; end
            CODE_NEXT_TRACK, CODE_ERASE, CODE_HALT: begin
                key_hit = 1'b1;
                key_bit = BIT_B;
            end
            CODE_BLANK:                     begin key_hit = 1'b1; key_bit = BIT_START; end
            CODE_NEXT_FIELD:                begin key_hit = 1'b1; key_bit = BIT_SELECT; end
            CODE_CANCEL, CODE_PWR:          quit_key = 1'b1;
            default: ;
        endcase
    end

    // negative positions and positions beyond the SIZE_W range clamp to always-below or always-above
    always_comb begin
        x_neg = r_touch_x[31];
        x_big = !r_touch_x[31] && (|r_touch_x[30:SIZE_W]);
        y_neg = r_touch_y[31];
        y_big = !r_touch_y[31] && (|r_touch_y[30:SIZE_W]);
        x_scl = PROD_W'(PCT_FULL) * (PROD_W'(r_touch_x[SIZE_W-1:0]) + PROD_W'(1));
        y_scl = PROD_W'(PCT_FULL) * (PROD_W'(r_touch_y[SIZE_W-1:0]) + PROD_W'(1));
    end

    always_comb begin
        hits = '0;
        for (int i = 0; i < NUM_ZONES; i++) begin
            if (r_finger
                && !x_neg && (x_big || x_scl > r_x0p[i])
                && (x_neg || (!x_big && x_scl <= r_x1p[i]))
                && !y_neg && (y_big || y_scl > r_y0p[i])
                && (y_neg || (!y_big && y_scl <= r_y1p[i]))) begin
                hits[ZONE_TAB[i].hit_bit] = 1'b1;
            end
        end
    end

    always_comb begin
        n_touch_x   = r_touch_x;
        n_touch_y   = r_touch_y;
        n_finger    = r_finger;
        n_moved     = r_moved;
        n_keys      = r_keys;
        n_zone      = r_zone;
        n_quit      = r_quit;
        n_vol       = r_vol;
        n_plus_cnt  = r_plus_cnt;
        n_minus_cnt = r_minus_cnt;
        zone_now    = r_moved ? hits : r_zone;
        vol_mid     = r_vol;

        if (zone_now[ZONE_VOL_UP]) begin
            if (r_plus_cnt == 5'd0 || r_plus_cnt == HOLD_FIRST) begin
                vol_mid = vol_up(r_vol);
            end
        end
        n_out.volume = vol_mid;
        if (zone_now[ZONE_VOL_DOWN]) begin
            if (r_minus_cnt == 5'd0 || r_minus_cnt == HOLD_FIRST) begin
                n_out.volume = vol_down(vol_mid);
            end
        end
        n_out.buttons   = r_keys | zone_now[7:0];
        n_out.zone_hits = zone_now;
        n_out.quit      = r_quit;

        if (in_acc) begin
            if (i_in.mode) begin
                n_zone      = zone_now;
                n_vol       = n_out.volume;
                n_plus_cnt  = zone_now[ZONE_VOL_UP] ? hold_next(r_plus_cnt) : 5'd0;
                n_minus_cnt = zone_now[ZONE_VOL_DOWN] ? hold_next(r_minus_cnt) : 5'd0;
                n_quit      = 1'b0;
                n_moved     = 1'b0;
            end else if (i_in.event_type == EV_ABS) begin
                unique case (i_in.event_code)
                    ABS_X, ABS_MT_X: begin
                        n_touch_x = i_in.event_value;
                        n_moved   = 1'b1;
                    end
                    ABS_Y, ABS_MT_Y: begin
                        n_touch_y = i_in.event_value;
                        n_moved   = 1'b1;
                    end
                    ABS_MT_TRACK: begin
                        n_finger = !i_in.event_value[31];
                        n_moved  = 1'b1;
                    end
                    default: ;
                endcase
            end else if (i_in.event_type == EV_KEY) begin
                if (touch_key) begin
                    n_finger = pressed;
                    n_moved  = 1'b1;
                end
                if (key_hit) begin
                    n_keys[key_bit] = pressed;
                end
                if (quit_key && pressed) begin
                    n_quit = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ZONES; i++) begin
                r_x0p[i] <= edge_prod(ZONE_TAB[i].x0, PANEL_WIDTH_RESET);
                r_x1p[i] <= edge_prod(ZONE_TAB[i].x1, PANEL_WIDTH_RESET);
                r_y0p[i] <= edge_prod(ZONE_TAB[i].y0, PANEL_HEIGHT_RESET);
                r_y1p[i] <= edge_prod(ZONE_TAB[i].y1, PANEL_HEIGHT_RESET);
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            for (int i = 0; i < NUM_ZONES; i++) begin
                if (i_cfg_index == CFG_PANEL_WIDTH) begin
                    r_x0p[i] <= edge_prod(ZONE_TAB[i].x0, i_cfg_data);
                    r_x1p[i] <= edge_prod(ZONE_TAB[i].x1, i_cfg_data);
                end
                if (i_cfg_index == CFG_PANEL_HEIGHT) begin
                    r_y0p[i] <= edge_prod(ZONE_TAB[i].y0, i_cfg_data);
                    r_y1p[i] <= edge_prod(ZONE_TAB[i].y1, i_cfg_data);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_x   <= '0;
            r_touch_y   <= '0;
            r_finger    <= 1'b0;
            r_moved     <= 1'b0;
            r_keys      <= '0;
            r_zone      <= '0;
            r_quit      <= 1'b0;
            r_vol       <= VOL_RESET;
            r_plus_cnt  <= '0;
            r_minus_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_touch_x   <= n_touch_x;
            r_touch_y   <= n_touch_y;
            r_finger    <= n_finger;
            r_moved     <= n_moved;
            r_keys      <= n_keys;
            r_zone      <= n_zone;
            r_quit      <= n_quit;
            r_vol       <= n_vol;
            r_plus_cnt  <= n_plus_cnt;
            r_minus_cnt <= n_minus_cnt;
            if (in_acc && i_in.mode) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.mode) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
